### src/lrf_pkg.sv
// Shared types and constants for the rectangle fill byte stream block.
// Used by the clipper, the byte sequencer and the top level; no dependencies.
package lrf_pkg;

  localparam int COORD_W = 16;
  localparam int COLOR_W = 16;

  // Request kinds carried on the input tuser bit.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PULL  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_COL_OFFSET = 1'b0;
  localparam logic CFG_ROW_OFFSET = 1'b1;

  // Display command bytes and the zero pad byte.
  localparam logic [7:0] DCS_COL_SET   = 8'h2A;
  localparam logic [7:0] DCS_ROW_SET   = 8'h2B;
  localparam logic [7:0] DCS_MEM_WRITE = 8'h2C;
  localparam logic [7:0] PAD_BYTE      = 8'h00;

  // Header positions; the ones not listed send a zero data byte.
  localparam logic [3:0] STEP_COL_CMD   = 4'd0;
  localparam logic [3:0] STEP_COL_START = 4'd2;
  localparam logic [3:0] STEP_COL_END   = 4'd4;
  localparam logic [3:0] STEP_ROW_CMD   = 4'd5;
  localparam logic [3:0] STEP_ROW_START = 4'd7;
  localparam logic [3:0] STEP_ROW_END   = 4'd9;
  localparam logic [3:0] STEP_MEM_CMD   = 4'd10;
  localparam logic [3:0] PIXEL_PHASE    = 4'd11;

  typedef struct packed {
    logic       ok;
    logic [7:0] col_start;
    logic [7:0] col_end;
    logic [7:0] row_start;
    logic [7:0] row_end;
  } window_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       is_data;
    logic       last;
  } result_t;

endpackage

### src/lrf_clip.sv
// Rectangle clipper: rejects empty rectangles, clips to the panel and forms
// the window bytes and the pixel count. Pure combinational; uses lrf_pkg.
module lrf_clip import lrf_pkg::*; #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 160,
  parameter int PIX_W        = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1)
) (
  input  logic signed [COORD_W-1:0] rect_x,
  input  logic signed [COORD_W-1:0] rect_y,
  input  logic signed [COORD_W-1:0] rect_width,
  input  logic signed [COORD_W-1:0] rect_height,
  input  logic [7:0]                column_offset,
  input  logic [7:0]                row_offset,
  output window_t                   win,
  output logic [PIX_W-1:0]          pixel_count
);

  // Three extra bits keep position plus length free of overflow.
  localparam int CW   = COORD_W + 3;
  localparam int WLEN = $clog2(PANEL_WIDTH + 1);
  localparam int HLEN = $clog2(PANEL_HEIGHT + 1);
  localparam int PROD_W = WLEN + HLEN;
  localparam logic signed [CW-1:0] LIM_X = CW'(PANEL_WIDTH);
  localparam logic signed [CW-1:0] LIM_Y = CW'(PANEL_HEIGHT);

  typedef struct packed {
    logic                 ok;
    logic signed [CW-1:0] first;
    logic signed [CW-1:0] last;
    logic signed [CW-1:0] len;
  } axis_t;

  function automatic axis_t clip_axis(input logic signed [CW-1:0] pos,
                                      input logic signed [CW-1:0] len,
                                      input logic signed [CW-1:0] lim);
    axis_t                r;
    logic signed [CW-1:0] p1;
    logic signed [CW-1:0] l1;
    logic signed [CW-1:0] l2;
    p1 = (pos < 0) ? '0 : pos;
    l1 = (pos < 0) ? len + pos : len;
    l2 = (p1 + l1 > lim) ? lim - p1 : l1;
    r.ok    = (len > 0) && (p1 < lim) && (l2 > 0);
    r.first = p1;
    r.last  = p1 + l2 - CW'(1);
    r.len   = l2;
    return r;
  endfunction

  axis_t             xa;
  axis_t             ya;
  logic [PROD_W-1:0] prod;

  assign xa = clip_axis(CW'(rect_x), CW'(rect_width), LIM_X);
  assign ya = clip_axis(CW'(rect_y), CW'(rect_height), LIM_Y);

  assign win.ok        = xa.ok && ya.ok;
  assign win.col_start = xa.first[7:0] + column_offset;
  assign win.col_end   = xa.last[7:0] + column_offset;
  assign win.row_start = ya.first[7:0] + row_offset;
  assign win.row_end   = ya.last[7:0] + row_offset;

  assign prod        = PROD_W'(xa.len[WLEN-1:0]) * PROD_W'(ya.len[HLEN-1:0]);
  assign pixel_count = prod[PIX_W-1:0];

endmodule

### src/lrf_seq.sv
// Byte sequencer: holds the latched window, color and pixel count, and on
// each pull request selects the next header or color byte. Uses lrf_pkg.
module lrf_seq import lrf_pkg::*; #(
  parameter int PIX_W = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               cmd,
  input  window_t            win,
  input  logic [PIX_W-1:0]   pixel_count,
  input  logic [COLOR_W-1:0] fill_color,
  output result_t            res,
  output logic               busy
);

  logic               busy_next;
  logic [3:0]         header_step;
  logic [3:0]         header_step_next;
  window_t            window;
  window_t            window_next;
  logic [COLOR_W-1:0] latched_color;
  logic [COLOR_W-1:0] latched_color_next;
  logic [PIX_W-1:0]   pixels_left;
  logic [PIX_W-1:0]   pixels_left_next;
  logic               low_byte_next;
  logic               low_byte_next_next;
  logic [PIX_W-1:0]   pixels_dec;

  assign pixels_dec = (pixels_left != '0) ? pixels_left - PIX_W'(1) : pixels_left;

  always_comb begin
    busy_next          = busy;
    header_step_next   = header_step;
    window_next        = window;
    latched_color_next = latched_color;
    pixels_left_next   = pixels_left;
    low_byte_next_next = low_byte_next;
    res                = '0;
    if (advance) begin
      if (cmd == CMD_START) begin
        // A start always drops any running stream; an empty rectangle leaves
        // the block idle.
        busy_next = win.ok;
        if (win.ok) begin
          window_next        = win;
          latched_color_next = fill_color;
          pixels_left_next   = pixel_count;
          header_step_next   = STEP_COL_CMD;
          low_byte_next_next = 1'b0;
        end
      end else if (busy) begin
        res.valid = 1'b1;
        if (header_step < PIXEL_PHASE) begin
          header_step_next = header_step + 4'd1;
          res.is_data      = 1'b1;
          res.data         = PAD_BYTE;
          unique case (header_step)
            STEP_COL_CMD: begin
              res.data    = DCS_COL_SET;
              res.is_data = 1'b0;
            end
            STEP_COL_START: res.data = window.col_start;
            STEP_COL_END:   res.data = window.col_end;
            STEP_ROW_CMD: begin
              res.data    = DCS_ROW_SET;
              res.is_data = 1'b0;
            end
            STEP_ROW_START: res.data = window.row_start;
            STEP_ROW_END:   res.data = window.row_end;
            STEP_MEM_CMD: begin
              res.data    = DCS_MEM_WRITE;
              res.is_data = 1'b0;
            end
            default: res.data = PAD_BYTE;
          endcase
        end else if (!low_byte_next) begin
          low_byte_next_next = 1'b1;
          res.is_data        = 1'b1;
          res.data           = latched_color[15:8];
        end else begin
          low_byte_next_next = 1'b0;
          pixels_left_next   = pixels_dec;
          res.is_data        = 1'b1;
          res.data           = latched_color[7:0];
          res.last           = (pixels_dec == '0);
          if (pixels_dec == '0) begin
            busy_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      header_step   <= '0;
      window        <= '0;
      latched_color <= '0;
      pixels_left   <= '0;
      low_byte_next <= 1'b0;
    end else begin
      busy          <= busy_next;
      header_step   <= header_step_next;
      window        <= window_next;
      latched_color <= latched_color_next;
      pixels_left   <= pixels_left_next;
      low_byte_next <= low_byte_next_next;
    end
  end

endmodule

### src/lcd_rect_fill_byte_stream_core.sv
// Timing: an accepted request is held in the input register, and its byte is
// then loaded into the result register, which drives the output.
// Throughput: one request per cycle while the output is not stalled; the
// sequencer state updates once per request as it moves between the two registers.
// Reset (rst, synchronous, active high) makes the block idle with empty
// registers and sets the column offset to 2 and the row offset to 1.
module lcd_rect_fill_byte_stream_core import lrf_pkg::*; #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 160
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // rect_x, rect_y, rect_width, rect_height, fill_color
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tuser,   // is_data
  output logic        m_tlast,   // last_byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int PIX_W = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1);

  logic                       in_vld;
  logic                       in_cmd;
  logic signed [COORD_W-1:0]  in_x;
  logic signed [COORD_W-1:0]  in_y;
  logic signed [COORD_W-1:0]  in_w;
  logic signed [COORD_W-1:0]  in_h;
  logic [COLOR_W-1:0]         in_color;
  logic [7:0]                 column_offset;
  logic [7:0]                 row_offset;
  logic                       fire;
  window_t                    win;
  logic [PIX_W-1:0]           pixel_count;
  result_t                    res;
  result_t                    out_reg;
  logic                       busy;

  // A request leaves the input register when the output register is free or
  // being emptied in the same cycle.
  assign fire      = in_vld && (!out_reg.valid || m_tready);
  assign s_tready  = !in_vld || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd   <= s_tuser;
      in_x     <= s_tdata[15:0];
      in_y     <= s_tdata[31:16];
      in_w     <= s_tdata[47:32];
      in_h     <= s_tdata[63:48];
      in_color <= s_tdata[79:64];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset <= 8'd2;
      row_offset    <= 8'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COL_OFFSET: column_offset <= cfg_data;
        CFG_ROW_OFFSET: row_offset    <= cfg_data;
        default:        column_offset <= column_offset;
      endcase
    end
  end

  lrf_clip #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .PIX_W        (PIX_W)
  ) u_clip (
    .rect_x        (in_x),
    .rect_y        (in_y),
    .rect_width    (in_w),
    .rect_height   (in_h),
    .column_offset (column_offset),
    .row_offset    (row_offset),
    .win           (win),
    .pixel_count   (pixel_count)
  );

  lrf_seq #(
    .PIX_W (PIX_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .advance     (fire),
    .cmd         (in_cmd),
    .win         (win),
    .pixel_count (pixel_count),
    .fill_color  (in_color),
    .res         (res),
    .busy        (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg.valid <= 1'b0;
    end else if (fire) begin
      out_reg.valid <= res.valid;
    end else if (m_tready) begin
      out_reg.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_reg.data    <= res.data;
      out_reg.is_data <= res.is_data;
      out_reg.last    <= res.last;
    end
  end

  assign m_tvalid = out_reg.valid;
  assign m_tdata  = out_reg.data;
  assign m_tuser  = out_reg.is_data;
  assign m_tlast  = out_reg.last;

`ifndef SYNTHESIS
  a_start_no_result: assert property (@(posedge clk) disable iff (rst)
    fire && in_cmd == CMD_START |=> !out_reg.valid)
    else $error("start request produced a result byte");

  a_idle_pull_no_result: assert property (@(posedge clk) disable iff (rst)
    fire && in_cmd == CMD_PULL && !busy |=> !out_reg.valid)
    else $error("pull while idle produced a result byte");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res.valid && res.last |=> !busy)
    else $error("sequencer still busy after the last byte");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_vld && out_reg.valid && !m_tready)
    else $error("input stalled without a blocked request");
`endif

endmodule
